/* rtl/mcop_pkg.sv */
// Shared types, constants and tables for the Monte Carlo option payoff mean block.
// No dependencies; used by every rtl module of the block.
`timescale 1ns / 1ps

package mcop_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int SAMPLE_FRAC_BITS = 12;
  localparam int Q_W              = 32;
  localparam int SUM_W            = 64;
  localparam int SAMPLE_W         = 16;
  localparam int TOTAL_W          = 24;
  localparam int MODE_W           = 2;
  localparam int INDEX_W          = 3;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int EXP_W  = 66 - FRAC_BITS;
  localparam int REM_W  = FRAC_BITS + 6;
  localparam int K_W    = 7;
  localparam int SH_W   = 8;
  localparam int TERM_W = 31;
  localparam int TSUM_W = 32;
  localparam int R30_W  = 30;
  localparam int TN_W   = 4;
  localparam int TAYLOR_TERMS = 12;
  localparam int WIDE_W = 35;

  localparam int ROOT_W = (33 + FRAC_BITS) / 2;
  localparam int SQ_W   = 2 * ROOT_W;

  localparam int LN2_Q = int'((64'd2977044472 + (64'd1 << (31 - FRAC_BITS)))
                              >> (32 - FRAC_BITS));
  localparam logic signed [EXP_W-1:0] EXP_HI = EXP_W'((33 - FRAC_BITS) * LN2_Q);
  localparam logic signed [EXP_W-1:0] EXP_LO = EXP_W'(-(FRAC_BITS + 2) * LN2_Q);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [INDEX_W-1:0] REG_SPOT     = 3'd0;
  localparam logic [INDEX_W-1:0] REG_STRIKE_A = 3'd1;
  localparam logic [INDEX_W-1:0] REG_STRIKE_B = 3'd2;
  localparam logic [INDEX_W-1:0] REG_VARIANCE = 3'd3;
  localparam logic [INDEX_W-1:0] REG_RATE     = 3'd4;
  localparam logic [INDEX_W-1:0] REG_EXPIRY   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_MODE     = 3'd6;

  localparam logic [MODE_W-1:0] MODE_CALL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIGITAL = 2'd2;

  typedef struct packed {
    logic [Q_W-1:0]        spot;
    logic [Q_W-1:0]        strike_a;
    logic [Q_W-1:0]        strike_b;
    logic [Q_W-1:0]        variance;
    logic signed [Q_W-1:0] rate;
    logic [Q_W-1:0]        expiry;
    logic [MODE_W-1:0]     mode;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] zmag;
    logic                neg;
    logic                last;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RT, ST_RT_HOLD, ST_SQRT,
    ST_EXP_CHK, ST_EXP_RED, ST_EXP_MUL, ST_EXP_REC, ST_EXP_COR, ST_EXP_SCALE,
    ST_DRIFT_MUL, ST_DRIFT, ST_DISC, ST_ARG, ST_ARG_HOLD, ST_PATH_MUL, ST_ACC,
    ST_DIV_INIT, ST_DIV, ST_PRICE_MUL, ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    RET_DRIFT, RET_DISC, RET_PATH
  } exp_ret_t;

  // floor(2^34 / n), with 2^34 - 1 for n = 1; one correction step fixes the quotient
  function automatic logic [MUL_A_W-1:0] recip_of(input logic [TN_W-1:0] n);
    logic [MUL_A_W-1:0] m;
    case (n)
      4'd1:    m = 34'd17179869183;
      4'd2:    m = 34'd8589934592;
      4'd3:    m = 34'd5726623061;
      4'd4:    m = 34'd4294967296;
      4'd5:    m = 34'd3435973836;
      4'd6:    m = 34'd2863311530;
      4'd7:    m = 34'd2454267026;
      4'd8:    m = 34'd2147483648;
      4'd9:    m = 34'd1908874353;
      4'd10:   m = 34'd1717986918;
      4'd11:   m = 34'd1561806289;
      4'd12:   m = 34'd1431655765;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/mcop_front.sv */
// Input side: accepts samples, splits them into magnitude and sign, queues them.
// Depends on mcop_pkg.
`timescale 1ns / 1ps

module mcop_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  logic signed [mcop_pkg::SAMPLE_W-1:0] normal_sample,
  input  logic                             last_sample,
  output logic                             item_valid,
  input  logic                             item_ready,
  output mcop_pkg::item_t                  item
);

  mcop_pkg::item_t                   queue [mcop_pkg::QUEUE_DEPTH];
  logic [mcop_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mcop_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mcop_pkg::QPTR_W:0]         fill;
  mcop_pkg::item_t                   incoming;
  logic                              push;
  logic                              pop;

  always_comb begin
    incoming.neg  = normal_sample[mcop_pkg::SAMPLE_W-1];
    incoming.zmag = normal_sample[mcop_pkg::SAMPLE_W-1] ? (~normal_sample + 1'b1)
                                                        : normal_sample;
    incoming.last = last_sample;
  end

  assign sample_ready = (fill != (mcop_pkg::QPTR_W + 1)'(mcop_pkg::QUEUE_DEPTH));
  assign item_valid   = (fill != '0);
  assign item         = queue[rd_ptr];
  assign push         = sample_valid && sample_ready;
  assign pop          = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/mcop_back.sv */
// Sequencer: run setup, exponential, payoff accumulation, mean and discounting.
// One shared registered multiplier, iterative square root and divider. Depends on mcop_pkg.
`timescale 1ns / 1ps

module mcop_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mcop_pkg::cfg_t                    cfg,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  mcop_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [mcop_pkg::Q_W-1:0]          price,
  output logic [mcop_pkg::TOTAL_W-1:0]      path_total,
  output logic                              saturated
);

  localparam int F  = mcop_pkg::FRAC_BITS;
  localparam int DC_W = $clog2(mcop_pkg::SUM_W);
  localparam logic [DC_W-1:0] DIV_LAST = DC_W'(mcop_pkg::SUM_W - 1);
  localparam logic signed [mcop_pkg::REM_W-1:0] LN2_R = mcop_pkg::REM_W'(mcop_pkg::LN2_Q);

  mcop_pkg::back_state_t state, state_next, ret_state;
  mcop_pkg::exp_ret_t    exp_ret;

  logic [mcop_pkg::SAMPLE_W-1:0]     cur_zmag;
  logic                              cur_neg;
  logic                              cur_last;
  logic [mcop_pkg::SUM_W-1:0]        payoff_sum;
  logic [COUNT_BITS-1:0]             path_count;
  logic [mcop_pkg::Q_W-1:0]          drifted;
  logic [mcop_pkg::ROOT_W-1:0]       root_var;
  logic [mcop_pkg::Q_W-1:0]          discount;
  logic                              sat_seen;
  logic signed [mcop_pkg::EXP_W-1:0] rt;
  logic signed [mcop_pkg::EXP_W-1:0] exp_x;
  logic [mcop_pkg::Q_W-1:0]          exp_res;
  logic signed [mcop_pkg::REM_W-1:0] rem;
  logic signed [mcop_pkg::K_W-1:0]   k;
  logic [mcop_pkg::TERM_W-1:0]       term;
  logic [mcop_pkg::TSUM_W-1:0]       tsum;
  logic [mcop_pkg::TN_W-1:0]         tn;
  logic [mcop_pkg::TERM_W-1:0]       tx;
  logic [mcop_pkg::PROD_W-1:0]       prod;
  logic [mcop_pkg::SQ_W-1:0]         sq_n;
  logic [mcop_pkg::SQ_W-1:0]         sq_res;
  logic [mcop_pkg::SQ_W-1:0]         sq_bit;
  logic [mcop_pkg::SUM_W-1:0]        dv_q;
  logic [COUNT_BITS-1:0]             dv_r;
  logic [DC_W-1:0]                   dv_cnt;

  logic                              mul_en;
  logic [mcop_pkg::MUL_A_W-1:0]      mul_a;
  logic [mcop_pkg::MUL_B_W-1:0]      mul_b;
  logic                              out_load;

  logic                              count_full;
  logic [mcop_pkg::Q_W-1:0]          rate_mag;
  logic                              satq_hi;
  logic [mcop_pkg::Q_W-1:0]          satq_val;
  logic [mcop_pkg::SQ_W-1:0]         sq_trial;
  logic                              sq_take;
  logic [mcop_pkg::SQ_W-1:0]         sq_res_next;
  logic                              rem_neg;
  logic                              rem_ge;
  logic [mcop_pkg::TERM_W-1:0]       q0;
  logic [mcop_pkg::TERM_W+mcop_pkg::TN_W-1:0] qn;
  logic [mcop_pkg::TERM_W+mcop_pkg::TN_W-1:0] q_rem;
  logic [mcop_pkg::TERM_W-1:0]       q_fix;
  logic signed [mcop_pkg::SH_W-1:0]  sh;
  logic [mcop_pkg::WIDE_W-1:0]       wide;
  logic [mcop_pkg::Q_W-1:0]          ka_lo;
  logic [mcop_pkg::Q_W-1:0]          ka_hi;
  logic [mcop_pkg::Q_W-1:0]          payoff;
  logic [mcop_pkg::SUM_W:0]          sum_ext;
  logic [COUNT_BITS:0]               dv_trial;
  logic                              dv_take;
  logic [mcop_pkg::SUM_W-1:0]        mean;
  logic [mcop_pkg::Q_W-1:0]          mean32;
  logic [mcop_pkg::ROOT_W+mcop_pkg::SAMPLE_W-mcop_pkg::SAMPLE_FRAC_BITS-1:0] arg_mag;

  assign count_full = (path_count == '1);
  assign rate_mag   = cfg.rate[mcop_pkg::Q_W-1] ? (~cfg.rate + 1'b1) : cfg.rate;
  assign satq_hi    = |prod[mcop_pkg::PROD_W-1:F+mcop_pkg::Q_W];
  assign satq_val   = satq_hi ? '1 : prod[F+mcop_pkg::Q_W-1:F];

  always_comb begin
    sq_trial    = sq_res + sq_bit;
    sq_take     = (sq_n >= sq_trial);
    sq_res_next = sq_take ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  end

  assign rem_neg = rem[mcop_pkg::REM_W-1];
  assign rem_ge  = (rem >= LN2_R);

  always_comb begin
    q0    = prod[34 +: mcop_pkg::TERM_W];
    qn    = q0 * tn;
    q_rem = (mcop_pkg::TERM_W + mcop_pkg::TN_W)'(tx) - qn;
    q_fix = (q_rem >= (mcop_pkg::TERM_W + mcop_pkg::TN_W)'(tn)) ? (q0 + 1'b1) : q0;
  end

  always_comb begin
    sh   = mcop_pkg::SH_W'(k) + mcop_pkg::SH_W'(F - 30);
    wide = mcop_pkg::WIDE_W'(tsum) << sh[1:0];
  end

  always_comb begin
    ka_lo = (cfg.strike_a < cfg.strike_b) ? cfg.strike_a : cfg.strike_b;
    ka_hi = (cfg.strike_a < cfg.strike_b) ? cfg.strike_b : cfg.strike_a;
    case (cfg.mode)
      mcop_pkg::MODE_CALL:    payoff = (satq_val > cfg.strike_a) ? satq_val - cfg.strike_a : '0;
      mcop_pkg::MODE_PUT:     payoff = (cfg.strike_a > satq_val) ? cfg.strike_a - satq_val : '0;
      mcop_pkg::MODE_DIGITAL: payoff = (satq_val >= ka_lo && satq_val <= ka_hi)
                                       ? mcop_pkg::Q_W'(64'd1 << F) : '0;
      default:                payoff = '0;
    endcase
    sum_ext = {1'b0, payoff_sum} + (mcop_pkg::SUM_W + 1)'(payoff);
  end

  always_comb begin
    dv_trial = {dv_r, dv_q[mcop_pkg::SUM_W-1]};
    dv_take  = (dv_trial >= {1'b0, path_count});
    mean     = (path_count == '0) ? '0 : dv_q;
    mean32   = (|mean[mcop_pkg::SUM_W-1:mcop_pkg::Q_W]) ? '1 : mean[mcop_pkg::Q_W-1:0];
    arg_mag  = prod[mcop_pkg::SAMPLE_FRAC_BITS +: $bits(arg_mag)];
  end

  always_comb begin
    case (exp_ret)
      mcop_pkg::RET_DRIFT: ret_state = mcop_pkg::ST_DRIFT_MUL;
      mcop_pkg::RET_DISC:  ret_state = mcop_pkg::ST_DISC;
      default:             ret_state = mcop_pkg::ST_PATH_MUL;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      mcop_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (path_count == '0) begin
            state_next = mcop_pkg::ST_RT;
          end else if (!count_full) begin
            state_next = mcop_pkg::ST_ARG;
          end else if (item.last) begin
            state_next = mcop_pkg::ST_DIV_INIT;
          end
        end
      end
      mcop_pkg::ST_RT:      state_next = mcop_pkg::ST_RT_HOLD;
      mcop_pkg::ST_RT_HOLD: state_next = mcop_pkg::ST_SQRT;
      mcop_pkg::ST_SQRT: begin
        if (sq_bit == mcop_pkg::SQ_W'(1)) begin
          state_next = mcop_pkg::ST_EXP_CHK;
        end
      end
      mcop_pkg::ST_EXP_CHK: begin
        if (exp_x > mcop_pkg::EXP_HI || exp_x < mcop_pkg::EXP_LO) begin
          state_next = ret_state;
        end else begin
          state_next = mcop_pkg::ST_EXP_RED;
        end
      end
      mcop_pkg::ST_EXP_RED: begin
        if (!rem_neg && !rem_ge) begin
          state_next = mcop_pkg::ST_EXP_MUL;
        end
      end
      mcop_pkg::ST_EXP_MUL: state_next = mcop_pkg::ST_EXP_REC;
      mcop_pkg::ST_EXP_REC: state_next = mcop_pkg::ST_EXP_COR;
      mcop_pkg::ST_EXP_COR: begin
        state_next = (tn == mcop_pkg::TN_W'(mcop_pkg::TAYLOR_TERMS)) ? mcop_pkg::ST_EXP_SCALE
                                                                    : mcop_pkg::ST_EXP_MUL;
      end
      mcop_pkg::ST_EXP_SCALE: state_next = ret_state;
      mcop_pkg::ST_DRIFT_MUL: state_next = mcop_pkg::ST_DRIFT;
      mcop_pkg::ST_DRIFT:     state_next = mcop_pkg::ST_EXP_CHK;
      mcop_pkg::ST_DISC:      state_next = mcop_pkg::ST_ARG;
      mcop_pkg::ST_ARG:       state_next = mcop_pkg::ST_ARG_HOLD;
      mcop_pkg::ST_ARG_HOLD:  state_next = mcop_pkg::ST_EXP_CHK;
      mcop_pkg::ST_PATH_MUL:  state_next = mcop_pkg::ST_ACC;
      mcop_pkg::ST_ACC:       state_next = cur_last ? mcop_pkg::ST_DIV_INIT : mcop_pkg::ST_IDLE;
      mcop_pkg::ST_DIV_INIT:  state_next = mcop_pkg::ST_DIV;
      mcop_pkg::ST_DIV: begin
        if (dv_cnt == DIV_LAST) begin
          state_next = mcop_pkg::ST_PRICE_MUL;
        end
      end
      mcop_pkg::ST_PRICE_MUL: state_next = mcop_pkg::ST_OUT;
      mcop_pkg::ST_OUT: begin
        if (!result_valid || result_ready) begin
          state_next = mcop_pkg::ST_IDLE;
        end
      end
      default: state_next = mcop_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == mcop_pkg::ST_IDLE);
    out_load   = (state == mcop_pkg::ST_OUT) && (!result_valid || result_ready);
    mul_en     = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      mcop_pkg::ST_RT: begin
        mul_a = mcop_pkg::MUL_A_W'(rate_mag);
        mul_b = cfg.expiry;
      end
      mcop_pkg::ST_EXP_MUL: begin
        mul_a = mcop_pkg::MUL_A_W'(term);
        mul_b = mcop_pkg::MUL_B_W'(rem) << (30 - F);
      end
      mcop_pkg::ST_EXP_REC: begin
        mul_a = mcop_pkg::recip_of(tn);
        mul_b = mcop_pkg::MUL_B_W'(prod[30 +: mcop_pkg::TERM_W]);
      end
      mcop_pkg::ST_DRIFT_MUL: begin
        mul_a = mcop_pkg::MUL_A_W'(cfg.spot);
        mul_b = exp_res;
      end
      mcop_pkg::ST_ARG: begin
        mul_a = mcop_pkg::MUL_A_W'(root_var);
        mul_b = mcop_pkg::MUL_B_W'(cur_zmag);
      end
      mcop_pkg::ST_PATH_MUL: begin
        mul_a = mcop_pkg::MUL_A_W'(drifted);
        mul_b = exp_res;
      end
      mcop_pkg::ST_PRICE_MUL: begin
        mul_a = mcop_pkg::MUL_A_W'(mean32);
        mul_b = discount;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcop_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payoff_sum   <= '0;
      path_count   <= '0;
      sat_seen     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        mcop_pkg::ST_IDLE: begin
          if (item_valid && path_count != '0 && count_full) begin
            sat_seen <= 1'b1;
          end
        end
        mcop_pkg::ST_EXP_CHK: begin
          if (exp_x > mcop_pkg::EXP_HI) begin
            sat_seen <= 1'b1;
          end
        end
        mcop_pkg::ST_EXP_SCALE: begin
          if (!sh[mcop_pkg::SH_W-1] && (|wide[mcop_pkg::WIDE_W-1:mcop_pkg::Q_W])) begin
            sat_seen <= 1'b1;
          end
        end
        mcop_pkg::ST_DRIFT: begin
          if (satq_hi) begin
            sat_seen <= 1'b1;
          end
        end
        mcop_pkg::ST_ACC: begin
          path_count <= path_count + 1'b1;
          if (sum_ext[mcop_pkg::SUM_W] || satq_hi) begin
            sat_seen <= 1'b1;
          end
          payoff_sum <= sum_ext[mcop_pkg::SUM_W] ? '1 : sum_ext[mcop_pkg::SUM_W-1:0];
        end
        mcop_pkg::ST_PRICE_MUL: begin
          if (|mean[mcop_pkg::SUM_W-1:mcop_pkg::Q_W]) begin
            sat_seen <= 1'b1;
          end
        end
        mcop_pkg::ST_OUT: begin
          if (out_load) begin
            payoff_sum   <= '0;
            path_count   <= '0;
            sat_seen     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (out_load) begin
      price      <= satq_val;
      path_total <= mcop_pkg::TOTAL_W'(path_count);
      saturated  <= sat_seen | satq_hi;
    end
    case (state)
      mcop_pkg::ST_IDLE: begin
        cur_zmag <= item.zmag;
        cur_neg  <= item.neg;
        cur_last <= item.last;
      end
      mcop_pkg::ST_RT_HOLD: begin
        rt     <= cfg.rate[mcop_pkg::Q_W-1]
                  ? -mcop_pkg::EXP_W'(prod[mcop_pkg::SUM_W-1:F])
                  :  mcop_pkg::EXP_W'(prod[mcop_pkg::SUM_W-1:F]);
        sq_n   <= mcop_pkg::SQ_W'(cfg.variance) << F;
        sq_res <= '0;
        sq_bit <= mcop_pkg::SQ_W'(1) << (mcop_pkg::SQ_W - 2);
      end
      mcop_pkg::ST_SQRT: begin
        if (sq_take) begin
          sq_n <= sq_n - sq_trial;
        end
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        if (sq_bit == mcop_pkg::SQ_W'(1)) begin
          root_var <= sq_res_next[mcop_pkg::ROOT_W-1:0];
          exp_x    <= rt - mcop_pkg::EXP_W'(cfg.variance >> 1);
          exp_ret  <= mcop_pkg::RET_DRIFT;
        end
      end
      mcop_pkg::ST_EXP_CHK: begin
        if (exp_x > mcop_pkg::EXP_HI) begin
          exp_res <= '1;
        end else if (exp_x < mcop_pkg::EXP_LO) begin
          exp_res <= '0;
        end
        rem <= exp_x[mcop_pkg::REM_W-1:0];
        k   <= '0;
      end
      mcop_pkg::ST_EXP_RED: begin
        if (rem_neg) begin
          rem <= rem + LN2_R;
          k   <= k - 1'b1;
        end else if (rem_ge) begin
          rem <= rem - LN2_R;
          k   <= k + 1'b1;
        end else begin
          term <= mcop_pkg::TERM_W'(64'd1 << 30);
          tsum <= mcop_pkg::TSUM_W'(64'd1 << 30);
          tn   <= mcop_pkg::TN_W'(1);
        end
      end
      mcop_pkg::ST_EXP_REC: begin
        tx <= prod[30 +: mcop_pkg::TERM_W];
      end
      mcop_pkg::ST_EXP_COR: begin
        term <= q_fix;
        tsum <= tsum + mcop_pkg::TSUM_W'(q_fix);
        tn   <= tn + 1'b1;
      end
      mcop_pkg::ST_EXP_SCALE: begin
        if (!sh[mcop_pkg::SH_W-1]) begin
          exp_res <= (|wide[mcop_pkg::WIDE_W-1:mcop_pkg::Q_W]) ? '1 : wide[mcop_pkg::Q_W-1:0];
        end else begin
          exp_res <= tsum >> (-sh);
        end
      end
      mcop_pkg::ST_DRIFT: begin
        drifted <= satq_val;
        exp_x   <= -rt;
        exp_ret <= mcop_pkg::RET_DISC;
      end
      mcop_pkg::ST_DISC: begin
        discount <= exp_res;
      end
      mcop_pkg::ST_ARG_HOLD: begin
        exp_x   <= cur_neg ? -mcop_pkg::EXP_W'(arg_mag) : mcop_pkg::EXP_W'(arg_mag);
        exp_ret <= mcop_pkg::RET_PATH;
      end
      mcop_pkg::ST_DIV_INIT: begin
        dv_q   <= payoff_sum;
        dv_r   <= '0;
        dv_cnt <= '0;
      end
      mcop_pkg::ST_DIV: begin
        dv_r   <= dv_take ? COUNT_BITS'(dv_trial - {1'b0, path_count})
                          : dv_trial[COUNT_BITS-1:0];
        dv_q   <= {dv_q[mcop_pkg::SUM_W-2:0], dv_take};
        dv_cnt <= dv_cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/monte_carlo_option_payoff_mean.sv */
// Top level of the Monte Carlo option payoff mean block: configuration registers,
// input queue and sequencer. Depends on mcop_pkg, mcop_front and mcop_back.
`timescale 1ns / 1ps

// Each sample is one simulated path: the block forms the terminal price from the
// drifted spot and exp(sqrt(v)*z), adds the call, put or double-digital payoff to a
// 64-bit sum, and on a sample marked last delivers the discounted mean with the path
// count and a sticky saturation flag. Each sample runs the
// iterative exponential: up to 18 range-reduction steps and twelve Taylor terms, each
// a multiply, a reciprocal multiply and a correction on the single shared multiplier;
// an exponent argument outside the usable range skips both. The first sample of a run
// also computes r*T, a 24-step square root and two more exponentials; the last runs
// the 64-step divider with its setup, the discount product and the output load. A
// four-entry input queue takes samples while the sequencer is busy, and the result
// register holds a price until it is taken.
module monte_carlo_option_payoff_mean #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [mcop_pkg::INDEX_W-1:0]         wr_index,
  input  logic [mcop_pkg::Q_W-1:0]             wr_data,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic signed [mcop_pkg::SAMPLE_W-1:0] normal_sample,
  input  logic                                 last_sample,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [mcop_pkg::Q_W-1:0]             price,
  output logic [mcop_pkg::TOTAL_W-1:0]         path_total,
  output logic                                 saturated
);

  mcop_pkg::cfg_t  cfg;
  mcop_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spot     <= 32'd6553600;
      cfg.strike_a <= 32'd6553600;
      cfg.strike_b <= 32'd6553600;
      cfg.variance <= 32'd2621;
      cfg.rate     <= 32'sd3277;
      cfg.expiry   <= 32'd65536;
      cfg.mode     <= mcop_pkg::MODE_CALL;
    end else if (wr_en) begin
      case (wr_index)
        mcop_pkg::REG_SPOT:     cfg.spot     <= wr_data;
        mcop_pkg::REG_STRIKE_A: cfg.strike_a <= wr_data;
        mcop_pkg::REG_STRIKE_B: cfg.strike_b <= wr_data;
        mcop_pkg::REG_VARIANCE: cfg.variance <= wr_data;
        mcop_pkg::REG_RATE:     cfg.rate     <= wr_data;
        mcop_pkg::REG_EXPIRY:   cfg.expiry   <= wr_data;
        mcop_pkg::REG_MODE:     cfg.mode     <= wr_data[mcop_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  mcop_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .normal_sample (normal_sample),
    .last_sample   (last_sample),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  mcop_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .price        (price),
    .path_total   (path_total),
    .saturated    (saturated)
  );

endmodule

/* rtl/mcop_checker.sv */
// Port-level checks for the Monte Carlo option payoff mean block, bound to its top level.
// Depends on mcop_pkg and monte_carlo_option_payoff_mean.
`timescale 1ns / 1ps

module mcop_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         sample_valid,
  input logic                         sample_ready,
  input logic                         last_sample,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [mcop_pkg::Q_W-1:0]     price,
  input logic [mcop_pkg::TOTAL_W-1:0] path_total,
  input logic                         saturated
);

  logic [7:0] pending;
  logic       run_end;
  logic       taken;

  assign run_end = sample_valid && sample_ready && last_sample;
  assign taken   = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({run_end, taken})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_result_has_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pending != '0))
    else $error("result without a closed run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(price) && $stable(path_total) && $stable(saturated))
    else $error("result changed while stalled");

endmodule

bind monte_carlo_option_payoff_mean mcop_checker u_mcop_checker (.*);
